### rtl/core/fsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fsa_pkg;

    // Sizes of the slot space and of one link entry
    localparam int MAX_SLOTS  = 256;
    localparam int SLOT_W     = 8;
    localparam int LINK_W     = 9;
    localparam int COUNT_W    = 9;

    localparam logic [COUNT_W-1:0] SLOTS_USED_RESET = 9'd256;
    localparam logic [LINK_W-1:0]  HEAD_EMPTY       = 9'd256;

    // Operation codes
    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_REBUILD = 2'd2,
        OP_CHECK   = 2'd3
    } t_op;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_ALLOC   = 2'd1,
        ST_REBUILD = 2'd2,
        ST_CHECK   = 2'd3
    } t_state;

    typedef struct packed {
        t_op                op;
        logic [SLOT_W-1:0]  slot;
    } t_req;

    typedef struct packed {
        logic [SLOT_W-1:0]  granted_slot;
        logic               ok;
    } t_rsp;

endpackage

`default_nettype wire

### rtl/core/free_list_slot_allocator.sv
// Channel      | Signals                       | Handshake
// -------------+-------------------------------+-------------------------------------
// command      | start, busy, i_req (op, slot) | taken when start high and busy low
// result       | o_done, o_result              | one-cycle strobe, no back-pressure
// config       | i_cfg_we, i_cfg_wdata         | slots in use written when i_cfg_we high
//
// Free updates the head on acceptance; alloc reads the link RAM, then moves the head.
// Rebuild writes one link per cycle after acceptance. Check follows one link per cycle
// through the RAM read port until it has counted the slots in use or meets a link
// out of range.
// The result strobe follows the last cycle; busy is low again in that same cycle.
// Synchronous reset empties the list (head past the end); link RAM is not cleared.
// The receiver cannot stall, so a result is never held back.
`timescale 1ns / 1ps
`default_nettype none

module free_list_slot_allocator (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [fsa_pkg::COUNT_W-1:0] i_cfg_wdata,
    input  wire logic                        start,
    output logic                             busy,
    input  wire fsa_pkg::t_req               i_req,
    output logic                             o_done,
    output fsa_pkg::t_rsp                    o_result
);

    import fsa_pkg::*;

    t_state                r_state, n_state;
    logic [COUNT_W-1:0]    r_slots_used;
    logic [LINK_W-1:0]     r_head, n_head;
    logic [SLOT_W-1:0]     r_idx, n_idx;
    logic [COUNT_W-1:0]    r_cnt, n_cnt;
    logic                  r_done, n_done;
    t_rsp                  r_result, n_result;

    logic                  accept;
    logic [COUNT_W-1:0]    active_n;
    logic                  ram_we;
    logic [SLOT_W-1:0]     ram_addr;
    logic [LINK_W-1:0]     ram_wdata;
    logic [LINK_W-1:0]     ram_rdata;
    logic                  head_in_range;
    logic                  link_in_range;
    logic                  rebuild_last;

    assign accept        = start && (r_state == ST_IDLE);
    assign busy          = (r_state != ST_IDLE);
    assign active_n      = (r_slots_used > COUNT_W'(MAX_SLOTS)) ? COUNT_W'(MAX_SLOTS)
                                                                : r_slots_used;
    assign head_in_range = (r_head < active_n);
    assign link_in_range = (ram_rdata < active_n);
    assign rebuild_last  = ({1'b0, r_idx} == (active_n - COUNT_W'(1)));

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots_used <= SLOTS_USED_RESET;
        end else if (i_cfg_we) begin
            r_slots_used <= i_cfg_wdata;
        end
    end

    // Link memory
    fsa_link_ram #(
        .DEPTH (MAX_SLOTS),
        .WIDTH (LINK_W)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_req.op)
                        OP_ALLOC:   n_state = head_in_range ? ST_ALLOC : ST_IDLE;
                        OP_REBUILD: n_state = (active_n != '0) ? ST_REBUILD : ST_IDLE;
                        OP_CHECK:   n_state = (active_n != '0 && head_in_range) ? ST_CHECK
                                                                                : ST_IDLE;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_ALLOC: begin
                n_state = ST_IDLE;
            end
            ST_REBUILD: begin
                if (rebuild_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_CHECK: begin
                if (r_cnt == active_n || !link_in_range) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath, memory access and result
    always_comb begin
        n_head    = r_head;
        n_idx     = r_idx;
        n_cnt     = r_cnt;
        n_done    = 1'b0;
        n_result  = '0;
        ram_we    = 1'b0;
        ram_addr  = r_head[SLOT_W-1:0];
        ram_wdata = r_head;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_req.op)
                        OP_ALLOC: begin
                            // read of the head's link is issued on acceptance
                            ram_addr = r_head[SLOT_W-1:0];
                            n_done   = !head_in_range;
                        end
                        OP_FREE: begin
                            // push onto the head; out-of-range slots ignored
                            if ({1'b0, i_req.slot} < active_n) begin
                                ram_we    = 1'b1;
                                ram_addr  = i_req.slot;
                                ram_wdata = r_head;
                                n_head    = {1'b0, i_req.slot};
                            end
                            n_done = 1'b1;
                        end
                        OP_REBUILD: begin
                            n_idx = '0;
                            if (active_n == '0) begin
                                n_head = '0;
                                n_done = 1'b1;
                            end
                        end
                        default: begin
                            // check: first link read from the head
                            ram_addr = r_head[SLOT_W-1:0];
                            n_cnt    = COUNT_W'(1);
                            if (active_n == '0) begin
                                n_done      = 1'b1;
                                n_result.ok = 1'b1;
                            end else if (!head_in_range) begin
                                n_done = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_ALLOC: begin
                n_head                = ram_rdata;
                n_done                = 1'b1;
                n_result.ok           = 1'b1;
                n_result.granted_slot = r_head[SLOT_W-1:0];
            end
            ST_REBUILD: begin
                ram_we    = 1'b1;
                ram_addr  = r_idx;
                ram_wdata = {1'b0, r_idx} + LINK_W'(1);
                n_idx     = r_idx + SLOT_W'(1);
                if (rebuild_last) begin
                    n_head = '0;
                    n_done = 1'b1;
                end
            end
            ST_CHECK: begin
                // follow the link just read
                ram_addr = ram_rdata[SLOT_W-1:0];
                if (r_cnt == active_n) begin
                    n_done      = 1'b1;
                    n_result.ok = !link_in_range;
                end else if (!link_in_range) begin
                    n_done = 1'b1;
                end else begin
                    n_cnt = r_cnt + COUNT_W'(1);
                end
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= HEAD_EMPTY;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_done  <= n_done;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_cnt    <= n_cnt;
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    // Every accepted transaction either completes next cycle or keeps the block busy
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (o_done || busy))
        else $error("accepted transaction neither completed nor busy");

    // The walk counter stays within the active slot count
    a_check_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHECK) |-> (r_cnt != '0 && r_cnt <= active_n))
        else $error("check walk count out of range");

    // Rebuild never writes past the active slot count
    a_rebuild_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_REBUILD) |-> ({1'b0, r_idx} < active_n))
        else $error("rebuild index beyond slot count");

    // Head never points beyond the empty marker
    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head <= HEAD_EMPTY))
        else $error("free head out of range");

    // A granted slot is reported only with ok
    a_grant_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.ok) |-> (o_result.granted_slot == '0))
        else $error("slot granted on failed transaction");

endmodule

`default_nettype wire

### rtl/core/fsa_link_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module fsa_link_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 9
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Single port, read-first, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire
